[sv/vpwe_pkg.sv]
// Package for the VGA pixel write engine: field widths, mode and register codes,
// the input item record and the mask and fill constants.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package vpwe_pkg;

    // Plane size default; the real value is a parameter of the top level.
    localparam int PLANE_BYTES_DEF = 65536;

    // Field widths.
    localparam int MODE_W      = 3;
    localparam int WIDTH_W     = 11;
    localparam int X_W         = 10;
    localparam int Y_W         = 10;
    localparam int COLOUR_W    = 8;
    localparam int PLANE_W     = 2;
    localparam int ROFF_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int OFF_W       = 16;
    localparam int NUM_PLANES  = 4;
    localparam int WORD_W      = NUM_PLANES * BYTE_W;
    localparam int PROD_W      = WIDTH_W + Y_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = WIDTH_W;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    // Pixel modes.
    localparam logic [MODE_W-1:0] MODE_1BPP      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_2BPP      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PLANAR    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LINEAR    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_UNCHAINED = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_MODE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [MODE_W-1:0]  PIXEL_MODE_RST   = MODE_LINEAR;
    localparam logic [WIDTH_W-1:0] SCREEN_WIDTH_RST = 11'd320;

    // Pixel masks and fill patterns.
    localparam logic [BYTE_W-1:0] MASK_1BIT = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_2BIT = 8'hC0;
    localparam logic [BYTE_W-1:0] FILL_ALL  = 8'hFF;
    localparam logic [BYTE_W-1:0] FILL_2BIT = 8'h55;

    // Function codes of an input item.
    localparam logic FUNC_DRAW = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic                func;
        logic [X_W-1:0]      x_pos;
        logic [Y_W-1:0]      y_pos;
        logic [COLOUR_W-1:0] colour;
        logic [PLANE_W-1:0]  read_plane;
        logic [ROFF_W-1:0]   read_offset;
    } t_item;

endpackage

`default_nettype wire

[sv/vpwe_store.sv]
// Framebuffer store of the VGA pixel write engine: one word per byte offset holding
// all four planes, with a registered read port, one write port and a clearing pass.
// Depends on vpwe_pkg.
`default_nettype none

module vpwe_store #(
    parameter int   PLANE_BYTES = vpwe_pkg::PLANE_BYTES_DEF,
    localparam int  ADDR_W      = $clog2(PLANE_BYTES)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_rd_en,
    input  wire logic [ADDR_W-1:0]           i_rd_addr,
    output logic      [vpwe_pkg::WORD_W-1:0] o_rd_data,
    input  wire logic                        i_wr_en,
    input  wire logic [ADDR_W-1:0]           i_wr_addr,
    input  wire logic [vpwe_pkg::WORD_W-1:0] i_wr_data,
    output logic                             o_clear_done
);
    import vpwe_pkg::*;

    logic [WORD_W-1:0] r_mem [PLANE_BYTES];
    logic [WORD_W-1:0] r_rd_data;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clearing;
    logic              n_clearing;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    // The clearing pass owns the write port until every word is zero.
    always_comb begin
        mem_we    = r_clearing | i_wr_en;
        mem_waddr = r_clearing ? r_clr_addr : i_wr_addr;
        mem_wdata = r_clearing ? '0 : i_wr_data;
        n_clearing = r_clearing && (r_clr_addr != ADDR_W'(PLANE_BYTES - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data    = r_rd_data;
    assign o_clear_done = !r_clearing;

endmodule

`default_nettype wire

[sv/vpwe_addr.sv]
// Byte offset unit of the VGA pixel write engine: bytes per row times the row,
// registered, plus the column part, wrapped to the plane size; reads pass read_offset.
// Depends on vpwe_pkg.
`default_nettype none

module vpwe_addr #(
    parameter int   PLANE_BYTES = vpwe_pkg::PLANE_BYTES_DEF,
    localparam int  ADDR_W      = $clog2(PLANE_BYTES)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_mul_en,
    input  wire logic [vpwe_pkg::MODE_W-1:0]  i_pixel_mode,
    input  wire logic [vpwe_pkg::WIDTH_W-1:0] i_screen_width,
    input  wire vpwe_pkg::t_item              i_item,
    output logic      [ADDR_W-1:0]            o_offset
);
    import vpwe_pkg::*;

    logic [WIDTH_W-1:0] row_bytes;
    logic [X_W-1:0]     col_bytes;
    logic               mode_ok;
    logic [PROD_W-1:0]  r_prod;
    logic [SUM_W-1:0]   sum;

    always_comb begin
        unique case (i_pixel_mode)
            MODE_1BPP, MODE_PLANAR: begin
                row_bytes = i_screen_width >> 3;
                col_bytes = i_item.x_pos >> 3;
                mode_ok   = 1'b1;
            end
            MODE_2BPP, MODE_UNCHAINED: begin
                row_bytes = i_screen_width >> 2;
                col_bytes = i_item.x_pos >> 2;
                mode_ok   = 1'b1;
            end
            MODE_LINEAR: begin
                row_bytes = i_screen_width;
                col_bytes = i_item.x_pos;
                mode_ok   = 1'b1;
            end
            default: begin
                row_bytes = '0;
                col_bytes = '0;
                mode_ok   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= PROD_W'(row_bytes * i_item.y_pos);
        end
    end

    // The plane size is a power of two, so wrapping keeps the low bits.
    always_comb begin
        sum = SUM_W'(r_prod) + SUM_W'(col_bytes);
        if (i_item.func == FUNC_READ) begin
            o_offset = i_item.read_offset[ADDR_W-1:0];
        end else if (mode_ok) begin
            o_offset = sum[ADDR_W-1:0];
        end else begin
            o_offset = '0;
        end
    end

endmodule

`default_nettype wire

[sv/vga_pixel_write_engine_top.sv]
// Top level of the VGA pixel write engine: stream ports, configuration registers,
// item sequencer and the pixel merge logic. Depends on vpwe_pkg, vpwe_addr and
// vpwe_store.
`default_nettype none

// Channel     Direction  Signals                          Contents
// s_axis      in         tvalid, tready, tdata, tuser     one draw or read request
// m_axis      out        tvalid, tready, tdata            byte and byte offset of the result
// i_cfg       in         i_cfg_we, i_cfg_index, i_cfg_data  pixel_mode, screen_width
//
// Each item passes through acceptance, the row multiply, the framebuffer read and
// the merge with write-back. Items are handled one at a time, so no two accesses
// of the single read-modify-write over the one store overlap. After reset a
// clearing pass zeroes the store, one word per cycle, while s_axis_tready stays
// low. A result waiting in the output register does not block acceptance; the
// merge stage holds its write until the register frees.
// PLANE_BYTES must be a power of two.

module vga_pixel_write_engine_top #(
    parameter int PLANE_BYTES = vpwe_pkg::PLANE_BYTES_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Input item stream.
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tdata from bit 0: x_pos[9:0], y_pos[19:10], colour[27:20], read_plane[29:28],
    // read_offset[45:30], zero fill[47:46].
    input  wire logic [vpwe_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // tuser: func (0 draw pixel, 1 read byte).
    input  wire logic                                 s_axis_tuser,
    // Result item stream.
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // tdata from bit 0: read_byte[7:0], byte_offset[23:8].
    output logic      [vpwe_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // Configuration write port.
    input  wire logic                                 i_cfg_we,
    input  wire logic [vpwe_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [vpwe_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import vpwe_pkg::*;

    localparam int ADDR_W = $clog2(PLANE_BYTES);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_READ = 4'b0100,
        S_MOD  = 4'b1000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    t_item               r_item;
    logic [MODE_W-1:0]   r_pixel_mode;
    logic [WIDTH_W-1:0]  r_screen_width;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic [OFF_W-1:0]    r_out_off;

    logic                clear_done;
    logic                in_accept;
    logic                out_free;
    logic                mul_en;
    logic                rd_en;
    logic                wr_en;
    logic [ADDR_W-1:0]   offset;
    logic [WORD_W-1:0]   rd_word;
    logic [WORD_W-1:0]   new_word;
    logic [BYTE_W-1:0]   result_byte;
    logic [BYTE_W-1:0]   mask;
    logic [BYTE_W-1:0]   fill;
    logic [BYTE_W-1:0]   plane_old [NUM_PLANES];
    logic [BYTE_W-1:0]   plane_new [NUM_PLANES];
    logic                mode_ok;

    // Config registers. The user's writes must arrive only while the block is idle; the block does not check.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_mode   <= PIXEL_MODE_RST;
            r_screen_width <= SCREEN_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PIXEL_MODE:   r_pixel_mode   <= i_cfg_data[MODE_W-1:0];
                CFG_SCREEN_WIDTH: r_screen_width <= i_cfg_data[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && clear_done;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign mul_en        = (r_state == S_MUL);
    assign rd_en         = (r_state == S_READ);

    // Sequencer: one item moves through the multiply, read and merge steps.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_accept) n_state = S_MUL;
            S_MUL:   n_state = S_READ;
            S_READ:  n_state = S_MOD;
            S_MOD:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The input item is held for the whole of its processing.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.func        <= s_axis_tuser;
            r_item.x_pos       <= s_axis_tdata[9:0];
            r_item.y_pos       <= s_axis_tdata[19:10];
            r_item.colour      <= s_axis_tdata[27:20];
            r_item.read_plane  <= s_axis_tdata[29:28];
            r_item.read_offset <= s_axis_tdata[45:30];
        end
        if (rd_en) begin
            r_addr <= offset;
        end
    end

    vpwe_addr #(
        .PLANE_BYTES    (PLANE_BYTES)
    ) u_addr (
        .i_clk          (i_clk),
        .i_mul_en       (mul_en),
        .i_pixel_mode   (r_pixel_mode),
        .i_screen_width (r_screen_width),
        .i_item         (r_item),
        .o_offset       (offset)
    );

    vpwe_store #(
        .PLANE_BYTES    (PLANE_BYTES)
    ) u_store (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rd_en        (rd_en),
        .i_rd_addr      (offset),
        .o_rd_data      (rd_word),
        .i_wr_en        (wr_en),
        .i_wr_addr      (r_addr),
        .i_wr_data      (new_word),
        .o_clear_done   (clear_done)
    );

    // Pixel merge. The stored word holds plane p in byte p. A two-bit colour
    // repeated four times equals the colour times the 0x55 fill pattern.
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            plane_old[p] = rd_word[p*BYTE_W +: BYTE_W];
            plane_new[p] = plane_old[p];
        end
        mask    = MASK_1BIT >> r_item.x_pos[2:0];
        fill    = '0;
        mode_ok = 1'b1;
        unique case (r_pixel_mode)
            MODE_1BPP: begin
                fill         = r_item.colour[0] ? FILL_ALL : '0;
                plane_new[0] = (plane_old[0] & ~mask) | (fill & mask);
            end
            MODE_2BPP: begin
                mask         = MASK_2BIT >> {r_item.x_pos[1:0], 1'b0};
                fill         = {4{r_item.colour[1:0]}} & FILL_ALL;
                plane_new[0] = (plane_old[0] & ~mask) | (fill & mask);
            end
            MODE_PLANAR: begin
                for (int p = 0; p < NUM_PLANES; p++) begin
                    plane_new[p] = r_item.colour[p] ? (plane_old[p] | mask)
                                                    : (plane_old[p] & ~mask);
                end
            end
            MODE_LINEAR: begin
                plane_new[0] = r_item.colour;
            end
            MODE_UNCHAINED: begin
                plane_new[r_item.x_pos[1:0]] = r_item.colour;
            end
            default: begin
                mode_ok = 1'b0;
            end
        endcase
        for (int p = 0; p < NUM_PLANES; p++) begin
            new_word[p*BYTE_W +: BYTE_W] = plane_new[p];
        end

        if (r_item.func == FUNC_READ) begin
            result_byte = plane_old[r_item.read_plane];
        end else if (!mode_ok) begin
            result_byte = '0;
        end else if (r_pixel_mode == MODE_LINEAR || r_pixel_mode == MODE_UNCHAINED) begin
            result_byte = r_item.colour;
        end else begin
            result_byte = plane_new[0];
        end
    end

    // A draw in a defined mode writes back once the result can be handed over.
    assign wr_en = (r_state == S_MOD) && out_free && (r_item.func == FUNC_DRAW) && mode_ok;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_MOD) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_MOD) && out_free) begin
            r_out_byte <= result_byte;
            r_out_off  <= OFF_W'(r_addr);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_off, r_out_byte};

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps
// Testbench for vga_pixel_write_engine_top: a shadow copy of the four byte planes
// predicts every result. Directed and random draw and read items run under random idling.
// Depends on vpwe_pkg and the RTL of the block.

module tb;
    import vpwe_pkg::*;

    localparam int STORE_BYTES   = PLANE_BYTES_DEF;
    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 927;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;

    // One result item as the block should return it.
    typedef struct packed {
        logic [BYTE_W-1:0] pix_byte;
        logic [OFF_W-1:0]  offset;
    } t_plot_result;

    // Scoreboard: keeps its own copy of the planes and registers, predicts a result
    // for each accepted item and compares each returned result with the oldest one.
    class plot_scoreboard;
        bit [BYTE_W-1:0]   shadow_planes [NUM_PLANES][STORE_BYTES];
        logic [MODE_W-1:0]  mode;
        logic [WIDTH_W-1:0] width;
        t_plot_result       expected_plots [$];
        logic [OFF_W-1:0]   last_offset;
        logic [PLANE_W-1:0] last_plane;
        int unsigned        mismatches;
        int unsigned        results_seen;

        function new();
            mode         = PIXEL_MODE_RST;
            width        = SCREEN_WIDTH_RST;
            last_offset  = '0;
            last_plane   = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == CFG_PIXEL_MODE)
                mode = data[MODE_W-1:0];
            else if (index == CFG_SCREEN_WIDTH)
                width = data;
        endfunction

        function int pending();
            return expected_plots.size();
        endfunction

        // Plots or reads one item on the shadow planes and queues the expected result.
        function void note_request(t_item rq);
            int unsigned       xs, ys, ws, lin;
            logic [OFF_W-1:0]  off;
            logic [BYTE_W-1:0] mask, fill, val;
            t_plot_result      res;
            xs   = rq.x_pos;
            ys   = rq.y_pos;
            ws   = width;
            lin  = 0;
            mask = '0;
            fill = '0;
            val  = '0;
            if (rq.func == FUNC_READ) begin
                off = rq.read_offset % STORE_BYTES;
                val = shadow_planes[rq.read_plane][off];
            end else begin
                // Byte offset and pixel mask first; the row pitch is truncated
                // when the width is not a multiple of the pixels per byte.
                case (mode)
                    MODE_1BPP, MODE_PLANAR: begin
                        lin  = (ws / 8) * ys + xs / 8;
                        mask = MASK_1BIT >> rq.x_pos[2:0];
                    end
                    MODE_2BPP, MODE_UNCHAINED: begin
                        lin  = (ws / 4) * ys + xs / 4;
                        mask = MASK_2BIT >> {rq.x_pos[1:0], 1'b0};
                    end
                    MODE_LINEAR: lin = ws * ys + xs;
                    default: lin = 0;
                endcase
                off = lin % STORE_BYTES;
                case (mode)
                    MODE_1BPP, MODE_2BPP: begin
                        fill = (mode == MODE_1BPP) ? {8{rq.colour[0]}} : {4{rq.colour[1:0]}};
                        val  = (shadow_planes[0][off] & ~mask) | (fill & mask);
                        shadow_planes[0][off] = val;
                    end
                    MODE_PLANAR: begin
                        for (int p = 0; p < NUM_PLANES; p++) begin
                            if (rq.colour[p])
                                shadow_planes[p][off] = shadow_planes[p][off] | mask;
                            else
                                shadow_planes[p][off] = shadow_planes[p][off] & ~mask;
                        end
                        val = shadow_planes[0][off];
                    end
                    MODE_LINEAR: begin
                        shadow_planes[0][off] = rq.colour;
                        val = rq.colour;
                    end
                    MODE_UNCHAINED: begin
                        shadow_planes[rq.x_pos[1:0]][off] = rq.colour;
                        val = rq.colour;
                    end
                    default: begin
                        // An undefined mode writes nothing and returns zeros.
                        off = '0;
                        val = '0;
                    end
                endcase
                last_offset = off;
                last_plane  = rq.x_pos[1:0];
            end
            res.pix_byte = val;
            res.offset   = off;
            expected_plots.push_back(res);
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] data);
            t_plot_result want;
            results_seen++;
            if (expected_plots.size() == 0) begin
                report($sformatf("result %06h arrived with no item pending", data));
            end else begin
                want = expected_plots.pop_front();
                if (data[7:0] !== want.pix_byte)
                    report($sformatf("read_byte %02h, expected %02h (offset %04h)",
                                     data[7:0], want.pix_byte, want.offset));
                if (data[23:8] !== want.offset)
                    report($sformatf("byte_offset %04h, expected %04h",
                                     data[23:8], want.offset));
            end
        endtask
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    plot_scoreboard sb = new();

    // While set, neither side idles: long stretches at full rate.
    bit quiet_phase = 1'b0;

    // Cluster state: a run of draws near one spot, often in the same byte.
    logic [X_W-1:0] cluster_x;
    logic [Y_W-1:0] cluster_y;
    int             cluster_left = 0;

    vga_pixel_write_engine_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Idle length: mostly none, sometimes a few cycles, now and then a long gap.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offers one item and returns at the edge where it is accepted. The valid stays
    // high after acceptance so a following item with no gap goes out back to back.
    task automatic offer_item(input t_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, it.read_offset, it.read_plane, it.colour, it.y_pos, it.x_pos};
        s_axis_tuser  <= it.func;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(it);
    endtask

    // Stops offering and waits until every expected result has come back, then a
    // few cycles more so the block is surely idle before a register write.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_register(index, data);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random fields everywhere, so bits that the operation ignores also toggle.
    function automatic t_item noise_item();
        t_item it;
        it.func        = $urandom_range(0, 1);
        it.x_pos       = $urandom;
        it.y_pos       = $urandom;
        it.colour      = $urandom;
        it.read_plane  = $urandom;
        it.read_offset = $urandom;
        return it;
    endfunction

    task automatic draw(input int x, input int y, input int c);
        t_item it;
        it        = noise_item();
        it.func   = FUNC_DRAW;
        it.x_pos  = x;
        it.y_pos  = y;
        it.colour = c;
        offer_item(it);
    endtask

    task automatic read_back(input int plane, input int offset);
        t_item it;
        it             = noise_item();
        it.func        = FUNC_READ;
        it.read_plane  = plane;
        it.read_offset = offset;
        offer_item(it);
    endtask

    // Most random items are clustered draws and reads of bytes just drawn, so the
    // read-modify-write path sees real history; the rest is plain noise.
    function automatic t_item next_random_item();
        t_item it;
        int    r;
        it = noise_item();
        r  = $urandom_range(0, 99);
        if (r < 55) begin
            if (cluster_left == 0) begin
                cluster_x    = $urandom;
                cluster_y    = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 63) : $urandom;
                cluster_left = $urandom_range(1, 8);
            end
            cluster_left--;
            it.func  = FUNC_DRAW;
            it.x_pos = cluster_x + $urandom_range(0, 7);
            it.y_pos = cluster_y;
        end else if (r < 70) begin
            it.func = FUNC_DRAW;
        end else if (r < 88) begin
            it.func        = FUNC_READ;
            it.read_offset = sb.last_offset;
            it.read_plane  = ($urandom_range(0, 1) == 1) ? sb.last_plane : $urandom;
        end else begin
            it.func = FUNC_READ;
        end
        return it;
    endfunction

    // Result side: checks every accepted result and idles at random. Once, while
    // items are still being offered, it holds off long enough that the block fills
    // up and has to stall its input.
    initial begin : result_sink
        int stall_left;
        bit pressure_done;
        stall_left    = 0;
        pressure_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (!pressure_done && sb.results_seen >= 150 && s_axis_tvalid) begin
                pressure_done = 1'b1;
                stall_left    = HOLD_CYCLES;
            end
            if (stall_left == 0 && !quiet_phase)
                stall_left = pick_gap();
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus: reset, a directed part per mode, then random phases with fresh
    // register settings, and finally the drain and the verdict.
    initial begin : stimulus
        int   sent;
        int   phase_len;
        int   mode_pick;
        logic [MODE_W-1:0] next_mode;
        logic [WIDTH_W-1:0] next_width;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The clearing pass keeps the input stalled; registers are written after it.
        do @(posedge i_clk); while (!s_axis_tready);

        // Linear byte mode at the widest screen: the far corner wraps to the last
        // byte of the plane.
        write_reg(CFG_PIXEL_MODE, MODE_LINEAR);
        write_reg(CFG_SCREEN_WIDTH, 11'd1024);
        draw(1023, 1023, 255);
        draw(0, 0, 0);
        read_back(0, 65535);
        read_back(3, 0);

        // One bit per pixel with a width that is not a multiple of eight, and
        // back-to-back read-modify-writes to one byte.
        settle();
        write_reg(CFG_PIXEL_MODE, MODE_1BPP);
        write_reg(CFG_SCREEN_WIDTH, 11'd330);
        draw(0, 0, 1);
        draw(7, 0, 1);
        draw(7, 0, 0);
        draw(1023, 1023, 1);
        read_back(0, 0);

        // Two bits per pixel at the narrowest screen.
        settle();
        write_reg(CFG_PIXEL_MODE, MODE_2BPP);
        write_reg(CFG_SCREEN_WIDTH, 11'd8);
        draw(0, 0, 3);
        draw(3, 0, 2);
        draw(1023, 1023, 1);

        // Four planes: set, then clear bits of one pixel and read two planes back.
        settle();
        write_reg(CFG_PIXEL_MODE, MODE_PLANAR);
        write_reg(CFG_SCREEN_WIDTH, 11'd640);
        draw(5, 2, 15);
        draw(5, 2, 10);
        read_back(1, 160);
        read_back(3, 160);

        // Unchained planar byte: the plane follows the low bits of x.
        settle();
        write_reg(CFG_PIXEL_MODE, MODE_UNCHAINED);
        write_reg(CFG_SCREEN_WIDTH, 11'd320);
        draw(1, 0, 8'hA5);
        draw(2, 0, 8'h5A);
        draw(1023, 1023, 255);
        read_back(1, 0);
        read_back(2, 0);

        // Undefined modes, one of them written with high data bits set.
        settle();
        write_reg(CFG_PIXEL_MODE, {8'hFF, 3'd5});
        draw(100, 100, 77);
        settle();
        write_reg(CFG_PIXEL_MODE, 3'd7);
        draw(3, 3, 3);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            mode_pick = $urandom_range(0, 11);
            next_mode = (mode_pick < 10) ? mode_pick % 5 : $urandom_range(5, 7);
            case ($urandom_range(0, 7))
                0:       next_width = 11'd8;
                1:       next_width = 11'd1024;
                default: next_width = $urandom_range(8, 1024);
            endcase
            write_reg(CFG_PIXEL_MODE, {8'($urandom), next_mode});
            write_reg(CFG_SCREEN_WIDTH, next_width);
            quiet_phase  = ($urandom_range(0, 3) == 0);
            cluster_left = 0;
            phase_len    = $urandom_range(30, 90);
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                offer_item(next_random_item());
                sent++;
            end
        end

        quiet_phase = 1'b0;
        settle();
        if (sb.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hard limit on the run, far above the slowest correct run including the
    // clearing pass after reset.
    initial begin : watchdog
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
sv/vpwe_pkg.sv
sv/vpwe_store.sv
sv/vpwe_addr.sv
sv/vga_pixel_write_engine_top.sv
sim/tb.sv
